/* hdl/qoa_pkg.sv */
// Shared types, constants and helpers for the quaternion orientation accumulator.
// Used by qoa_mac, qoa_dsu and quaternion_orientation_accumulator; no dependencies.
package qoa_pkg;

  localparam int CW     = 16;             // component width, signed Q2.14
  localparam int FRAC   = CW - 2;         // fraction bits of a component
  localparam int TOL_W  = 14;             // norm tolerance register width
  localparam int PROD_W = 2 * CW;         // one signed product
  localparam int ACC_W  = PROD_W + 2;     // sum of four products
  localparam int NORM_W = PROD_W + 1;     // sum of four squares
  localparam int ROOT_W = CW + 1;         // integer square root of the norm, quotient width
  localparam int DSU_W  = 2 * ROOT_W;     // shift-subtract datapath width
  localparam int NUM_W  = CW + FRAC;      // rescale numerator width
  localparam int PRE_W  = NUM_W - ROOT_W; // numerator bits above the quotient window

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam comp_t ONE_Q    = {2'b01, {FRAC{1'b0}}};

  localparam logic [NORM_W-1:0] NORM_ONE  = NORM_W'(1) << (2 * FRAC);
  localparam logic [DSU_W-1:0]  ROOT_BIT0 = DSU_W'(1) << (DSU_W - 2);

  // Hamilton product term signs, indexed by {component, term}; a set bit subtracts
  localparam logic [15:0] NEG_TAB = 16'h428E;

  typedef logic [0:0] dsu_mode_t;
  localparam dsu_mode_t DSU_SQRT = 1'b0;
  localparam dsu_mode_t DSU_DIV  = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic neg;
  } mac_ctrl_t;

  typedef struct packed {
    logic              start;
    dsu_mode_t         mode;
    logic [DSU_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } dsu_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              big;
    logic [ROOT_W-1:0] res;
  } dsu_stat_t;

  typedef struct packed {
    logic  sat;
    comp_t val;
  } rnd_t;

  // Round a 2*FRAC-fraction sum to FRAC fraction bits (half up), then saturate
  function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]      v;
    logic signed [ACC_W-FRAC:0] sh;
    logic                       ovf;
    rnd_t                       r;
    v   = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC - 1));
    sh  = v[ACC_W:FRAC];
    ovf = sh[ACC_W-FRAC:CW-1] != {(ACC_W-FRAC-CW+2){sh[CW-1]}};
    r.sat = ovf;
    if (ovf) begin
      r.val = sh[ACC_W-FRAC] ? COMP_MIN : COMP_MAX;
    end else begin
      r.val = sh[CW-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/qoa_mac.sv */
// Shared multiply-accumulate unit: registered signed product, then signed accumulate.
// Depends on qoa_pkg.
module qoa_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qoa_pkg::mac_ctrl_t                ctrl,
  input  qoa_pkg::comp_t                    a,
  input  qoa_pkg::comp_t                    b,
  output logic signed [qoa_pkg::ACC_W-1:0]  acc,
  output logic                              done
);

  localparam int PROD_W = qoa_pkg::PROD_W;
  localparam int ACC_W  = qoa_pkg::ACC_W;

  qoa_pkg::mac_ctrl_t        ctl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctrl;
      done_r <= ctl_r.valid && ctl_r.last;
    end
  end

  always_comb begin
    base = ctl_r.first ? '0 : acc_r;
    term = ctl_r.neg ? -ACC_W'(prod_r) : ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (ctl_r.valid) begin
      acc_r <= base + term;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

/* hdl/qoa_dsu.sv */
// Shared shift-subtract unit: one root bit or one quotient bit per cycle.
// Runs integer square root of the norm and the per-component rescale division. Depends on qoa_pkg.
module qoa_dsu (
  input  logic                clk,
  input  logic                rst_n,
  input  qoa_pkg::dsu_ctrl_t  ctrl,
  output qoa_pkg::dsu_stat_t  stat
);

  localparam int DSU_W  = qoa_pkg::DSU_W;
  localparam int ROOT_W = qoa_pkg::ROOT_W;
  localparam int NUM_W  = qoa_pkg::NUM_W;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  qoa_pkg::dsu_mode_t   mode_r;
  logic                 big_r;
  logic [DSU_W-1:0]     x_r;
  logic [DSU_W-1:0]     res_r;
  logic [DSU_W-1:0]     bit_r;
  logic [ROOT_W-1:0]    den_r;
  logic [DSU_W-1:0]     op_a;
  logic [DSU_W-1:0]     op_b;
  logic [DSU_W-1:0]     diff;
  logic                 ge;

  // the one compare-subtract both operations share
  always_comb begin
    if (mode_r == qoa_pkg::DSU_SQRT) begin
      op_a = x_r;
      op_b = res_r + bit_r;
    end else begin
      op_a = DSU_W'({x_r[ROOT_W-1:0], bit_r[ROOT_W-1]});
      op_b = DSU_W'(den_r);
    end
    ge   = op_a >= op_b;
    diff = op_a - op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode_r <= ctrl.mode;
      den_r  <= ctrl.den;
      res_r  <= '0;
      if (ctrl.mode == qoa_pkg::DSU_SQRT) begin
        x_r   <= ctrl.num;
        bit_r <= qoa_pkg::ROOT_BIT0;
        big_r <= 1'b0;
      end else begin
        // upper numerator bits preload the remainder; quotient overflow if they reach den
        x_r   <= DSU_W'(ctrl.num[NUM_W-1:ROOT_W]);
        bit_r <= DSU_W'(ctrl.num[ROOT_W-1:0]);
        big_r <= ROOT_W'(ctrl.num[NUM_W-1:ROOT_W]) >= ctrl.den;
      end
    end else if (busy_r) begin
      if (mode_r == qoa_pkg::DSU_SQRT) begin
        if (ge) begin
          x_r   <= diff;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        x_r   <= ge ? diff : op_a;
        res_r <= {res_r[DSU_W-2:0], ge};
        bit_r <= bit_r << 1;
      end
    end
  end

  always_comb begin
    stat.busy = busy_r;
    stat.done = done_r;
    stat.big  = big_r;
    stat.res  = res_r[ROOT_W-1:0];
  end

endmodule

/* hdl/quaternion_orientation_accumulator.sv */
// Quaternion orientation accumulator: Hamilton product, norm check, rescale. Uses qoa_pkg,
// qoa_mac and qoa_dsu. A load item goes straight to the output stage; a multiply runs 16 products
// and 4 squares through the one multiplier and, when it rescales, then a 17-step square root
// and four 17-step divisions on the shift-subtract unit.
// One item at a time; the next is taken once the result is in the output register.
// Synchronous reset: identity orientation, tolerance 16, no result pending.
module quaternion_orientation_accumulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  qoa_pkg::comp_t                   in_w,
  input  qoa_pkg::comp_t                   in_x,
  input  qoa_pkg::comp_t                   in_y,
  input  qoa_pkg::comp_t                   in_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output qoa_pkg::comp_t                   out_w,
  output qoa_pkg::comp_t                   out_x,
  output qoa_pkg::comp_t                   out_y,
  output qoa_pkg::comp_t                   out_z,
  output logic                             out_renormalized,
  output logic                             out_fault,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qoa_pkg::TOL_W-1:0]        cfg_data
);

  localparam int CW     = qoa_pkg::CW;
  localparam int FRAC   = qoa_pkg::FRAC;
  localparam int TOL_W  = qoa_pkg::TOL_W;
  localparam int ACC_W  = qoa_pkg::ACC_W;
  localparam int NORM_W = qoa_pkg::NORM_W;
  localparam int ROOT_W = qoa_pkg::ROOT_W;
  localparam int DSU_W  = qoa_pkg::DSU_W;
  localparam int NUM_W  = qoa_pkg::NUM_W;

  localparam logic [ROOT_W-1:0] Q_HALF = ROOT_W'(1) << (CW - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROD   = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]            state_r;
  logic [4:0]            step_r;
  logic [1:0]            wr_cnt_r;
  logic [1:0]            idx_r;
  logic [TOL_W-1:0]      tol_r;
  logic                  renorm_r;
  logic                  fault_r;
  logic [NORM_W-1:0]     n_r;
  logic [ROOT_W-1:0]     s_r;
  qoa_pkg::comp_t        orient_r [4];
  qoa_pkg::comp_t        bq_r [4];
  qoa_pkg::comp_t        p_r [4];
  logic                  out_valid_r;
  qoa_pkg::comp_t        out_w_r;
  qoa_pkg::comp_t        out_x_r;
  qoa_pkg::comp_t        out_y_r;
  qoa_pkg::comp_t        out_z_r;
  logic                  out_renorm_r;
  logic                  out_fault_r;

  logic [1:0]            t_idx;
  logic [1:0]            c_idx;
  logic [1:0]            rd_idx;
  qoa_pkg::comp_t        p_rd;
  qoa_pkg::mac_ctrl_t    mac_ctrl;
  qoa_pkg::comp_t        mac_a;
  qoa_pkg::comp_t        mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  logic                  mac_done;
  qoa_pkg::rnd_t         rnd;
  logic [NORM_W-1:0]     n_dev;
  logic                  n_zero;
  logic                  need_scale;
  logic [CW-1:0]         mag;
  logic [NUM_W-1:0]      div_num;
  qoa_pkg::dsu_ctrl_t    dsu_ctrl;
  qoa_pkg::dsu_stat_t    dsu_stat;
  logic                  q_big;
  qoa_pkg::comp_t        resc_val;
  logic                  resc_sat;
  logic                  in_accept;
  logic                  out_free;

  assign in_stall  = state_r != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign t_idx  = step_r[1:0];
  assign c_idx  = step_r[3:2];
  assign rd_idx = (state_r == S_SQ) ? t_idx : idx_r;
  assign p_rd   = p_r[rd_idx];

  // product terms: left operand follows the term, right operand is component xor term
  always_comb begin
    mac_ctrl = '0;
    mac_a    = p_rd;
    mac_b    = p_rd;
    if (state_r == S_PROD) begin
      mac_a          = orient_r[t_idx];
      mac_b          = bq_r[c_idx ^ t_idx];
      mac_ctrl.valid = !step_r[4];
      mac_ctrl.neg   = qoa_pkg::NEG_TAB[step_r[3:0]];
    end else if (state_r == S_SQ) begin
      mac_ctrl.valid = step_r[4:2] == 3'd0;
    end
    mac_ctrl.first = t_idx == 2'd0;
    mac_ctrl.last  = t_idx == 2'd3;
  end

  qoa_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  assign rnd = qoa_pkg::round_sat(mac_acc);

  always_comb begin
    n_dev      = (n_r > qoa_pkg::NORM_ONE) ? n_r - qoa_pkg::NORM_ONE : qoa_pkg::NORM_ONE - n_r;
    n_zero     = n_r == '0;
    need_scale = n_dev > NORM_W'({tol_r, {FRAC{1'b0}}});
  end

  // rescale numerator: |c| * 2^FRAC + s/2, rounds the quotient to nearest
  always_comb begin
    mag     = p_rd[CW-1] ? CW'(~p_rd + 1'b1) : p_rd;
    div_num = NUM_W'({mag, {FRAC{1'b0}}}) + NUM_W'(s_r >> 1);
  end

  always_comb begin
    dsu_ctrl.start = (state_r == S_CHK && !n_zero && need_scale) || (state_r == S_DSTART);
    dsu_ctrl.mode  = (state_r == S_CHK) ? qoa_pkg::DSU_SQRT : qoa_pkg::DSU_DIV;
    dsu_ctrl.num   = (state_r == S_CHK) ? DSU_W'(n_r) : DSU_W'(div_num);
    dsu_ctrl.den   = s_r;
  end

  qoa_dsu u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dsu_ctrl),
    .stat  (dsu_stat)
  );

  // clamp the quotient magnitude at half range; only a positive clamp is a fault
  always_comb begin
    q_big = dsu_stat.big || (dsu_stat.res >= Q_HALF);
    if (!p_rd[CW-1]) begin
      resc_sat = q_big;
      resc_val = q_big ? qoa_pkg::COMP_MAX : dsu_stat.res[CW-1:0];
    end else begin
      resc_sat = 1'b0;
      resc_val = q_big ? qoa_pkg::COMP_MIN : CW'(~dsu_stat.res[CW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      wr_cnt_r    <= '0;
      idx_r       <= '0;
      tol_r       <= TOL_W'(16);
      out_valid_r <= 1'b0;
      orient_r[0] <= qoa_pkg::ONE_Q;
      orient_r[1] <= '0;
      orient_r[2] <= '0;
      orient_r[3] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r  <= in_command ? S_FIN : S_PROD;
            step_r   <= '0;
            wr_cnt_r <= '0;
          end
        end
        S_PROD: begin
          if (!step_r[4]) begin
            step_r <= step_r + 1'b1;
          end
          if (mac_done) begin
            wr_cnt_r <= wr_cnt_r + 1'b1;
            if (wr_cnt_r == 2'd3) begin
              step_r  <= '0;
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (step_r[4:2] == 3'd0) begin
            step_r <= step_r + 1'b1;
          end
          if (mac_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          state_r <= (!n_zero && need_scale) ? S_ROOT : S_FIN;
        end
        S_ROOT: begin
          if (dsu_stat.done) begin
            idx_r   <= '0;
            state_r <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dsu_stat.done) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == 2'd3) ? S_FIN : S_DSTART;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            orient_r    <= p_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        renorm_r <= 1'b0;
        fault_r  <= 1'b0;
        if (in_accept && in_command) begin
          p_r[0] <= in_w;
          p_r[1] <= in_x;
          p_r[2] <= in_y;
          p_r[3] <= in_z;
        end else if (in_accept) begin
          bq_r[0] <= in_w;
          bq_r[1] <= in_x;
          bq_r[2] <= in_y;
          bq_r[3] <= in_z;
        end
      end
      S_PROD: begin
        if (mac_done) begin
          p_r[wr_cnt_r] <= rnd.val;
          fault_r       <= fault_r | rnd.sat;
        end
      end
      S_SQ: begin
        if (mac_done) begin
          n_r <= mac_acc[NORM_W-1:0];
        end
      end
      S_CHK: begin
        if (n_zero) begin
          fault_r <= 1'b1;
        end
      end
      S_ROOT: begin
        if (dsu_stat.done) begin
          s_r      <= dsu_stat.res;
          renorm_r <= 1'b1;
        end
      end
      S_DSTART: begin
      end
      S_DIV: begin
        if (dsu_stat.done) begin
          p_r[idx_r] <= resc_val;
          fault_r    <= fault_r | resc_sat;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_w_r      <= p_r[0];
          out_x_r      <= p_r[1];
          out_y_r      <= p_r[2];
          out_z_r      <= p_r[3];
          out_renorm_r <= renorm_r;
          out_fault_r  <= fault_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_w            = out_w_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_renormalized = out_renorm_r;
  assign out_fault        = out_fault_r;

  a_sq_after_four_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (wr_cnt_r == 2'd0))
    else $error("squares started before all four product components were written");

  a_dsu_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dsu_ctrl.start |-> !dsu_stat.busy)
    else $error("shift-subtract unit restarted while busy");

  a_dsu_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    dsu_stat.done |-> (state_r == S_ROOT || state_r == S_DIV))
    else $error("shift-subtract result arrived while the sequencer was not waiting");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item did not start processing");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for quaternion_orientation_accumulator.
// Depends on qoa_pkg and the block; predicts every result in place and checks it as it arrives.
`timescale 1ns / 100ps

module testbench;

  localparam logic CMD_MULTIPLY = 1'b0;
  localparam logic CMD_LOAD     = 1'b1;

  localparam int     CW       = qoa_pkg::CW;
  localparam int     FRAC     = qoa_pkg::FRAC;
  localparam longint Q_MAX    = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint Q_MIN    = -Q_MAX - 1;
  localparam longint HALF_LSB = 64'sd1 <<< (FRAC - 1);
  localparam longint NORM_ONE = 64'sd1 <<< (2 * FRAC);

  localparam qoa_pkg::comp_t C_MAX = qoa_pkg::COMP_MAX;
  localparam qoa_pkg::comp_t C_MIN = qoa_pkg::COMP_MIN;
  localparam qoa_pkg::comp_t C_ONE = qoa_pkg::ONE_Q;
  localparam qoa_pkg::comp_t C_ZERO = '0;

  typedef struct packed {
    qoa_pkg::comp_t w;
    qoa_pkg::comp_t x;
    qoa_pkg::comp_t y;
    qoa_pkg::comp_t z;
    logic           renorm;
    logic           fault;
  } orient_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_command;
  qoa_pkg::comp_t            in_w, in_x, in_y, in_z;
  logic                      out_valid;
  logic                      out_stall;
  qoa_pkg::comp_t            out_w, out_x, out_y, out_z;
  logic                      out_renormalized;
  logic                      out_fault;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [qoa_pkg::TOL_W-1:0] cfg_data;

  // predicted block state
  qoa_pkg::comp_t            orient_w, orient_x, orient_y, orient_z;
  logic [qoa_pkg::TOL_W-1:0] tol_model;

  orient_result_t pending_orient_q[$];

  int sender_idle_pct;
  int recv_stall_pct;
  int error_count;
  int items_sent;
  int loads_sent;
  int results_seen;
  int rescaled_seen;
  int faults_seen;
  int tol_writes;

  quaternion_orientation_accumulator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_w             (in_w),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_z             (in_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_w            (out_w),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_renormalized (out_renormalized),
    .out_fault        (out_fault),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending_orient_q.size());
    $display("quaternion_orientation_accumulator test failed");
    $finish;
  end

  // Apply one item to the predicted state and return the result it should produce.
  function automatic orient_result_t next_orientation(input logic cmd,
                                                      input qoa_pkg::comp_t bw,
                                                      input qoa_pkg::comp_t bx,
                                                      input qoa_pkg::comp_t by,
                                                      input qoa_pkg::comp_t bz);
    longint a[4];
    longint b[4];
    longint acc[4];
    longint p[4];
    longint n;
    longint diff;
    longint root;
    longint cand;
    longint mag;
    longint q;
    logic   flt;
    logic   rn;
    orient_result_t r;
    flt  = 1'b0;
    rn   = 1'b0;
    a[0] = orient_w; a[1] = orient_x; a[2] = orient_y; a[3] = orient_z;
    b[0] = bw; b[1] = bx; b[2] = by; b[3] = bz;
    if (cmd == CMD_LOAD) begin
      for (int i = 0; i < 4; i++) p[i] = b[i];
    end else begin
      acc[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
      acc[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
      acc[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
      acc[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
      // round half up: add half an LSB, then floor
      for (int i = 0; i < 4; i++) begin
        p[i] = (acc[i] + HALF_LSB) >>> FRAC;
        if (p[i] > Q_MAX) begin
          p[i] = Q_MAX;
          flt  = 1'b1;
        end else if (p[i] < Q_MIN) begin
          p[i] = Q_MIN;
          flt  = 1'b1;
        end
      end
      n    = p[0] * p[0] + p[1] * p[1] + p[2] * p[2] + p[3] * p[3];
      diff = (n > NORM_ONE) ? n - NORM_ONE : NORM_ONE - n;
      if (n == 0) begin
        flt = 1'b1;
      end else if (diff > (longint'(tol_model) <<< FRAC)) begin
        root = 0;
        for (int k = CW; k >= 0; k--) begin
          cand = root | (64'sd1 <<< k);
          if (cand * cand <= n) root = cand;
        end
        // divide by the root, nearest with ties away from zero
        for (int i = 0; i < 4; i++) begin
          mag = (p[i] < 0) ? -p[i] : p[i];
          q   = ((mag <<< FRAC) + root / 2) / root;
          if (q > Q_MAX + 1) q = Q_MAX + 1;
          p[i] = (p[i] < 0) ? -q : q;
          if (p[i] > Q_MAX) begin
            p[i] = Q_MAX;
            flt  = 1'b1;
          end
        end
        rn = 1'b1;
      end
    end
    orient_w = qoa_pkg::comp_t'(p[0]);
    orient_x = qoa_pkg::comp_t'(p[1]);
    orient_y = qoa_pkg::comp_t'(p[2]);
    orient_z = qoa_pkg::comp_t'(p[3]);
    r.w      = orient_w;
    r.x      = orient_x;
    r.y      = orient_y;
    r.z      = orient_z;
    r.renorm = rn;
    r.fault  = flt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: MISMATCH %s on result %0d: got %0d, expected %0d",
             $realtime, what, results_seen, got, want);
    error_count++;
  endtask

  // Drive one item, hold it until taken, then queue its prediction.
  task automatic send_item(input logic cmd, input qoa_pkg::comp_t w, input qoa_pkg::comp_t x,
                           input qoa_pkg::comp_t y, input qoa_pkg::comp_t z);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_w       <= w;
    in_x       <= x;
    in_y       <= y;
    in_z       <= z;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
    pending_orient_q.push_back(next_orientation(cmd, w, x, y, z));
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_orient_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [qoa_pkg::TOL_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tol_model = value;
    tol_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall, changed only at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    orient_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_orient_q.size() == 0) begin
        report_mismatch("unexpected result", out_w, 0);
      end else begin
        want = pending_orient_q.pop_front();
        if (want.renorm) rescaled_seen++;
        if (want.fault) faults_seen++;
        if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_renormalized !== want.renorm)
          report_mismatch("out_renormalized", out_renormalized, want.renorm);
        if (out_fault !== want.fault) report_mismatch("out_fault", out_fault, want.fault);
      end
    end
  end

  task automatic test_identity_hold();
    send_item(CMD_MULTIPLY, C_ONE, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_ZERO, C_ONE, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_ZERO, C_ZERO, C_ONE, C_ZERO);
  endtask

  task automatic test_load_extremes();
    send_item(CMD_LOAD, C_MAX, C_MIN, C_MAX, C_MIN);
    send_item(CMD_LOAD, C_MIN, C_MAX, C_ZERO, -16'sd1);
    // full-scale operands overflow the product
    send_item(CMD_MULTIPLY, C_MAX, C_MIN, C_MIN, C_MAX);
    send_item(CMD_LOAD, C_MIN, C_MIN, C_MIN, C_MIN);
    send_item(CMD_MULTIPLY, C_MIN, C_MIN, C_MIN, C_MIN);
  endtask

  task automatic test_zero_norm();
    send_item(CMD_LOAD, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_ONE, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_LOAD, C_ONE, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
  endtask

  task automatic test_rounding_ties();
    // exactly half an LSB: rounds up for positive, to zero for negative
    send_item(CMD_LOAD, 16'sd1, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, 16'sd8192, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_LOAD, -16'sd1, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, 16'sd8192, C_ZERO, C_ZERO, C_ZERO);
  endtask

  task automatic test_tolerance_extremes();
    set_tolerance('0);
    send_item(CMD_LOAD, C_ONE, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_ONE, 16'sd1, C_ZERO, C_ZERO);
    set_tolerance('1);
    send_item(CMD_LOAD, C_ONE, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, 16'sd8192, C_ZERO, C_ZERO, C_ZERO);
    send_item(CMD_MULTIPLY, C_MAX, C_MAX, C_ZERO, C_ZERO);
    set_tolerance(14'd16);
  endtask

  task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                   input logic [qoa_pkg::TOL_W-1:0] tol, input bit mid_pause);
    int             pick;
    logic           cmd;
    qoa_pkg::comp_t w, x, y, z;
    set_tolerance(tol);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) wait_for_results();
      pick = $urandom_range(99);
      cmd  = (pick < 25) ? CMD_LOAD : CMD_MULTIPLY;
      if (pick < 15 || (pick >= 70 && pick < 90)) begin
        w = qoa_pkg::comp_t'($urandom);
        x = qoa_pkg::comp_t'($urandom);
        y = qoa_pkg::comp_t'($urandom);
        z = qoa_pkg::comp_t'($urandom);
      end else if (pick < 70) begin
        // small rotation close to unit length, either sign
        w = qoa_pkg::comp_t'(int'(C_ONE) - int'($urandom_range(0, 64)));
        if ($urandom_range(7) == 0) w = -w;
        x = qoa_pkg::comp_t'(int'($urandom_range(0, 600)) - 300);
        y = qoa_pkg::comp_t'(int'($urandom_range(0, 600)) - 300);
        z = qoa_pkg::comp_t'(int'($urandom_range(0, 600)) - 300);
      end else if (pick < 98) begin
        w = qoa_pkg::comp_t'(int'($urandom_range(0, 4094)) - 2047);
        x = qoa_pkg::comp_t'(int'($urandom_range(0, 4094)) - 2047);
        y = qoa_pkg::comp_t'(int'($urandom_range(0, 4094)) - 2047);
        z = qoa_pkg::comp_t'(int'($urandom_range(0, 4094)) - 2047);
      end else begin
        w = C_ZERO;
        x = C_ZERO;
        y = C_ZERO;
        z = C_ZERO;
      end
      send_item(cmd, w, x, y, z);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_MULTIPLY;
    in_w            = '0;
    in_x            = '0;
    in_y            = '0;
    in_z            = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    items_sent      = 0;
    loads_sent      = 0;
    results_seen    = 0;
    rescaled_seen   = 0;
    faults_seen     = 0;
    tol_writes      = 0;
    orient_w        = C_ONE;
    orient_x        = '0;
    orient_y        = '0;
    orient_z        = '0;
    tol_model       = 14'd16;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_identity_hold();
    test_load_extremes();
    test_zero_norm();
    test_rounding_ties();
    test_tolerance_extremes();

    test_random_phase(300, 0, 0, 14'd16, 1'b0);
    test_random_phase(300, 54, 0, 14'($urandom_range(0, 63)), 1'b1);
    test_random_phase(300, 0, 54, '1, 1'b0);
    test_random_phase(300, 25, 25, 14'($urandom_range(0, 16383)), 1'b0);
    test_random_phase(60, 25, 25, '0, 1'b0);

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d items (%0d loads) over %0d tolerance writes and four idle patterns;",
             items_sent, loads_sent, tol_writes);
    $display("checked %0d results, %0d rescaled, %0d flagged, %0d mismatches",
             results_seen, rescaled_seen, faults_seen, error_count);
    if (error_count == 0) begin
      $display("quaternion_orientation_accumulator test passed");
    end else begin
      $display("quaternion_orientation_accumulator test failed");
    end
    $finish;
  end

endmodule
